FILE: rtl/core/fler_pkg.sv
// Shared types and constants of the frame buffer line and ellipse rasterizer.
package fler_pkg;

    // Screen and pixel defaults
    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_ROWS    = 64;
    localparam int SHADE_BITS     = 4;

    // Datapath widths
    localparam int COORD_W   = 13;
    localparam int ACC_W     = 48;
    localparam int ERR_W     = 12;
    localparam int ROW_SLOTS = 256;

    // Command codes
    localparam logic [2:0] REQ_PIXEL   = 3'd0;
    localparam logic [2:0] REQ_LINE    = 3'd1;
    localparam logic [2:0] REQ_OUTLINE = 3'd2;
    localparam logic [2:0] REQ_FILL    = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] x0;
        logic [7:0] y0;
        logic [7:0] x1;
        logic [7:0] y1;
        logic [7:0] rad_x;
        logic [7:0] rad_y;
        logic [3:0] pixel_shade;
    } t_cmd;

    typedef struct packed {
        logic [3:0] read_shade;
        logic       command_done;
    } t_res;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PIXEL,
        OP_LINE,
        OP_OUTLINE,
        OP_FILL,
        OP_READ
    } t_op;

    // Classified command as held in the queue
    typedef struct packed {
        t_op  op;
        logic zero_rad;
        t_cmd cmd;
    } t_qent;

    // Back end status seen by the front end
    typedef struct packed {
        logic clearing;
    } t_bstat;

endpackage

FILE: rtl/core/fler_ram.sv
// Generic single write port RAM with registered read.
module fler_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/fler_front.sv
// Command intake: classifies commands and queues them for the drawing engine.
module fler_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  fler_pkg::t_cmd  i_cmd,
    output logic            busy,
    input  fler_pkg::t_bstat i_bstat,
    output logic            o_q_valid,
    output fler_pkg::t_qent o_q_ent,
    input  logic            i_q_pop
);
    import fler_pkg::*;

    localparam int QD = 2;

    t_qent      r_ent [QD];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_qent      w_new;
    logic       w_push;

    // Classify the incoming command
    always_comb begin
        w_new.cmd      = i_cmd;
        w_new.zero_rad = (i_cmd.rad_x == 8'd0) && (i_cmd.rad_y == 8'd0);
        case (i_cmd.req_type)
            REQ_PIXEL:   w_new.op = OP_PIXEL;
            REQ_LINE:    w_new.op = OP_LINE;
            REQ_OUTLINE: w_new.op = OP_OUTLINE;
            REQ_FILL:    w_new.op = OP_FILL;
            REQ_READ:    w_new.op = OP_READ;
            default:     w_new.op = OP_NOP;
        endcase
    end

    assign busy      = (r_cnt == 2'(QD)) || i_bstat.clearing;
    assign w_push    = start && !busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_ent   = r_ent[r_rp];

    // Queue pointers
    always_comb begin
        n_wp  = w_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_q_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= w_new;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QD)) else $error("queue count above depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_q_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("push lost");
`endif
endmodule

FILE: rtl/core/fler_back.sv
// Drawing engine: clears the frame store and executes queued commands.
module fler_back #(
    parameter int COLS = fler_pkg::SCREEN_COLUMNS,
    parameter int ROWS = fler_pkg::SCREEN_ROWS,
    parameter int SB   = fler_pkg::SHADE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  fler_pkg::t_qent  i_q_ent,
    output logic             o_q_pop,
    output fler_pkg::t_bstat o_bstat,
    output logic             o_res_valid,
    output fler_pkg::t_res   o_res
);
    import fler_pkg::*;

    localparam int DEPTH = COLS * ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [COORD_W-1:0] COLS_S = COORD_W'(COLS);
    localparam logic signed [COORD_W-1:0] ROWS_S = COORD_W'(ROWS);

    typedef enum logic [22:0] {
        S_CLR  = 23'h000001,
        S_IDLE = 23'h000002,
        S_DISP = 23'h000004,
        S_LN   = 23'h000008,
        S_EXX  = 23'h000010,
        S_EYY  = 23'h000020,
        S_EP1M = 23'h000040,
        S_EP1I = 23'h000080,
        S_EP2M = 23'h000100,
        S_EP2I = 23'h000200,
        S_ETST = 23'h000400,
        S_EV   = 23'h000800,
        S_FRD  = 23'h001000,
        S_FWR  = 23'h002000,
        S_EUA  = 23'h004000,
        S_EUB  = 23'h008000,
        S_RRD  = 23'h010000,
        S_RW   = 23'h020000,
        S_SPAN = 23'h040000,
        S_RD0  = 23'h080000,
        S_RD1  = 23'h100000,
        S_DONE = 23'h200000,
        S_SPR  = 23'h400000
    } t_state;

    t_state r_state, n_state;
    t_qent  r_ent, n_ent;
    logic [AW-1:0] r_clr, n_clr;

    // Plot stage
    logic                      r_pv, n_pv;
    logic signed [COORD_W-1:0] r_px, n_px, r_py, n_py;

    // Line walker
    logic signed [COORD_W-1:0] r_lx, n_lx, r_ly, n_ly;
    logic [7:0]                r_ldx, n_ldx, r_ldy, n_ldy;
    logic                      r_lsx, n_lsx, r_lsy, n_lsy;
    logic signed [ERR_W-1:0]   r_lerr, n_lerr;

    // Ellipse tracer
    logic signed [COORD_W-1:0] r_ex, n_ex, r_ey, n_ey;
    logic signed [ACC_W-1:0]   r_xx, n_xx, r_yy, n_yy, r_sx, n_sx, r_sy, n_sy;
    logic signed [ACC_W-1:0]   r_edx, n_edx, r_edy, n_edy, r_err, n_err;
    logic [10:0]               r_n, n_n;
    logic                      r_ph, n_ph;
    logic [1:0]                r_q, n_q;

    // Span filler
    logic [ROW_SLOTS-1:0]      r_seen, n_seen;
    logic [8:0]                r_r, n_r;
    logic signed [COORD_W-1:0] r_w, n_w, r_i, n_i;
    logic                      r_half, n_half;

    // Result
    logic [3:0] r_rd, n_rd;
    logic       r_ov, n_ov;
    t_res       r_ores, n_ores;

    // Memory ports
    logic                fb_we;
    logic [AW-1:0]       fb_waddr, fb_raddr;
    logic [SB-1:0]       fb_wdata, fb_rdata;
    logic                row_we;
    logic [7:0]          row_addr;
    logic [COORD_W-1:0]  row_wdata, row_rdata;

    // Helpers
    logic signed [COORD_W-1:0] w_cx, w_cy, w_bx, w_by, w_rxs, w_rys, w_rr;
    logic signed [COORD_W-1:0] w_rowv, w_wsel;
    logic [7:0]                w_ldx, w_ldy;
    logic signed [ERR_W-1:0]   w_dxs, w_dys;
    logic                      w_c1, w_c2;
    logic [16:0]               w_ma;
    logic [7:0]                w_mb;
    logic [24:0]               w_prod;
    logic signed [ACC_W-1:0]   w_xx2, w_yy2, w_t;
    logic                      w_go, w_inb, w_rinb;
    logic [SB+3:0]             w_shx;
    logic [SB+3:0]             w_rdx;

    assign w_cx   = COORD_W'(r_ent.cmd.x0);
    assign w_cy   = COORD_W'(r_ent.cmd.y0);
    assign w_bx   = COORD_W'(r_ent.cmd.x1);
    assign w_by   = COORD_W'(r_ent.cmd.y1);
    assign w_rxs  = COORD_W'(r_ent.cmd.rad_x);
    assign w_rys  = COORD_W'(r_ent.cmd.rad_y);
    assign w_rr   = COORD_W'(r_r);
    assign w_rowv = $signed(row_rdata);
    assign w_xx2  = r_xx <<< 1;
    assign w_yy2  = r_yy <<< 1;
    assign w_shx  = {{SB{1'b0}}, r_ent.cmd.pixel_shade};
    assign w_rdx  = {4'b0, fb_rdata};

    // Line setup values
    assign w_ldx = (r_ent.cmd.x1 > r_ent.cmd.x0) ? r_ent.cmd.x1 - r_ent.cmd.x0
                                                  : r_ent.cmd.x0 - r_ent.cmd.x1;
    assign w_ldy = (r_ent.cmd.y1 > r_ent.cmd.y0) ? r_ent.cmd.y1 - r_ent.cmd.y0
                                                  : r_ent.cmd.y0 - r_ent.cmd.y1;
    assign w_dxs = $signed(ERR_W'(r_ldx));
    assign w_dys = $signed(ERR_W'(r_ldy));
    assign w_c1  = r_lerr > -w_dxs;
    assign w_c2  = r_lerr < w_dys;

    // Shared multiplier for ellipse setup
    always_comb begin
        case (r_state)
            S_EXX:   begin w_ma = 17'(r_ent.cmd.rad_x);   w_mb = r_ent.cmd.rad_x; end
            S_EYY:   begin w_ma = 17'(r_ent.cmd.rad_y);   w_mb = r_ent.cmd.rad_y; end
            S_EP1M:  begin w_ma = {r_yy[15:0], 1'b0};      w_mb = r_ent.cmd.rad_x; end
            S_EP2M:  begin w_ma = {r_xx[15:0], 1'b0};      w_mb = r_ent.cmd.rad_y; end
            default: begin w_ma = 17'd0;                   w_mb = 8'd0;            end
        endcase
    end
    assign w_prod = {8'd0, w_ma} * {17'd0, w_mb};

    // Midpoint decision and loop test
    assign w_t  = (r_err <<< 1) + (r_ph ? r_edy : r_edx);
    assign w_go = !r_n[10] && (r_ph ? (r_sx <= r_sy) : (r_sx > r_sy));

    // Row width for the span filler
    always_comb begin
        if (r_r == 9'd0) begin
            w_wsel = (r_seen[0] && (w_rowv > w_rxs)) ? w_rowv : w_rxs;
        end else begin
            w_wsel = r_seen[r_r[7:0]] ? w_rowv : r_w;
        end
    end

    // Plot stage address and clipping
    assign w_inb  = (r_px >= 0) && (r_px < COLS_S) && (r_py >= 0) && (r_py < ROWS_S);
    assign w_rinb = (9'(r_ent.cmd.x0) < 9'(COLS)) && (9'(r_ent.cmd.y0) < 9'(ROWS));
    assign fb_we    = (r_state == S_CLR) || (r_pv && w_inb);
    assign fb_waddr = (r_state == S_CLR) ? r_clr
                    : AW'(r_py[8:0]) * AW'(COLS) + AW'(r_px[8:0]);
    assign fb_wdata = (r_state == S_CLR) ? '0 : w_shx[SB-1:0];
    assign fb_raddr = AW'(r_ent.cmd.y0) * AW'(COLS) + AW'(r_ent.cmd.x0);

    assign o_q_pop        = (r_state == S_IDLE) && i_q_valid;
    assign o_bstat.clearing = (r_state == S_CLR);
    assign o_res_valid    = r_ov;
    assign o_res          = r_ores;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_ent   = r_ent;
        n_clr   = r_clr;
        n_pv    = 1'b0;
        n_px    = r_px;
        n_py    = r_py;
        n_lx    = r_lx;
        n_ly    = r_ly;
        n_ldx   = r_ldx;
        n_ldy   = r_ldy;
        n_lsx   = r_lsx;
        n_lsy   = r_lsy;
        n_lerr  = r_lerr;
        n_ex    = r_ex;
        n_ey    = r_ey;
        n_xx    = r_xx;
        n_yy    = r_yy;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_edx   = r_edx;
        n_edy   = r_edy;
        n_err   = r_err;
        n_n     = r_n;
        n_ph    = r_ph;
        n_q     = r_q;
        n_seen  = r_seen;
        n_r     = r_r;
        n_w     = r_w;
        n_i     = r_i;
        n_half  = r_half;
        n_rd    = r_rd;
        n_ov    = 1'b0;
        n_ores  = r_ores;
        row_we    = 1'b0;
        row_addr  = r_ey[7:0];
        row_wdata = r_ex;

        case (r_state)
            // Zero the frame store after reset
            S_CLR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_q_valid) begin
                    n_ent   = i_q_ent;
                    n_rd    = 4'd0;
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                case (r_ent.op)
                    OP_PIXEL: begin
                        n_pv = 1'b1; n_px = w_cx; n_py = w_cy;
                        n_state = S_DONE;
                    end
                    OP_LINE: begin
                        n_lx   = w_cx;
                        n_ly   = w_cy;
                        n_ldx  = w_ldx;
                        n_ldy  = w_ldy;
                        n_lsx  = !(r_ent.cmd.x0 < r_ent.cmd.x1);
                        n_lsy  = !(r_ent.cmd.y0 < r_ent.cmd.y1);
                        n_lerr = (w_ldx > w_ldy) ? $signed(ERR_W'(w_ldx >> 1))
                                                 : -$signed(ERR_W'(w_ldy >> 1));
                        n_state = S_LN;
                    end
                    OP_OUTLINE: begin
                        if (r_ent.zero_rad) begin
                            n_pv = 1'b1; n_px = w_cx; n_py = w_cy;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_EXX;
                        end
                    end
                    OP_FILL: begin
                        n_seen = '0;
                        n_r    = 9'd0;
                        n_state = r_ent.zero_rad ? S_RRD : S_EXX;
                    end
                    OP_READ: n_state = S_RD0;
                    default: n_state = S_DONE;
                endcase
            end

            // Bresenham line, one pixel per cycle
            S_LN: begin
                n_pv = 1'b1; n_px = r_lx; n_py = r_ly;
                if ((r_lx == w_bx) && (r_ly == w_by)) begin
                    n_state = S_DONE;
                end else begin
                    n_lerr = r_lerr - (w_c1 ? w_dys : '0) + (w_c2 ? w_dxs : '0);
                    if (w_c1) begin
                        n_lx = r_lsx ? r_lx - COORD_W'(1) : r_lx + COORD_W'(1);
                    end
                    if (w_c2) begin
                        n_ly = r_lsy ? r_ly - COORD_W'(1) : r_ly + COORD_W'(1);
                    end
                end
            end

            // Ellipse setup products
            S_EXX: begin n_xx = ACC_W'(w_prod); n_state = S_EYY;  end
            S_EYY: begin n_yy = ACC_W'(w_prod); n_state = S_EP1M; end
            S_EP1M: begin n_sx = ACC_W'(w_prod); n_state = S_EP1I; end
            S_EP1I: begin
                n_edx = r_yy - r_sx;
                n_edy = r_xx;
                n_err = '0;
                n_sy  = '0;
                n_ex  = w_rxs;
                n_ey  = '0;
                n_n   = 11'd0;
                n_ph  = 1'b0;
                n_state = S_ETST;
            end
            S_EP2M: begin n_sy = ACC_W'(w_prod); n_state = S_EP2I; end
            S_EP2I: begin
                n_edy = r_xx - r_sy;
                n_edx = r_yy;
                n_err = '0;
                n_sx  = '0;
                n_ex  = '0;
                n_ey  = w_rys;
                n_n   = 11'd0;
                n_ph  = 1'b1;
                n_state = S_ETST;
            end

            S_ETST: begin
                if (w_go) begin
                    n_q = 2'd0;
                    n_state = (r_ent.op == OP_FILL) ? S_FRD : S_EV;
                end else if (!r_ph) begin
                    n_state = S_EP2M;
                end else if (r_ent.op == OP_FILL) begin
                    n_r = 9'd0;
                    n_state = S_RRD;
                end else begin
                    n_state = S_DONE;
                end
            end

            // Four-way symmetric outline plots
            S_EV: begin
                n_pv = 1'b1;
                n_px = ((r_q == 2'd1) || (r_q == 2'd2)) ? w_cx - r_ex : w_cx + r_ex;
                n_py = ((r_q == 2'd2) || (r_q == 2'd3)) ? w_cy - r_ey : w_cy + r_ey;
                n_q  = r_q + 2'd1;
                if (r_q == 2'd3) begin
                    n_state = S_EUA;
                end
            end

            // Record widest outline column per row for the fill
            S_FRD: begin
                n_state = ((r_ey >= 0) && (r_ey <= 255)) ? S_FWR : S_EUA;
            end
            S_FWR: begin
                if (!r_seen[r_ey[7:0]] || (w_rowv < r_ex)) begin
                    row_we = 1'b1;
                end
                n_seen[r_ey[7:0]] = 1'b1;
                n_state = S_EUA;
            end

            // Midpoint step, first half
            S_EUA: begin
                if (!r_ph) begin
                    n_ey  = r_ey + COORD_W'(1);
                    n_sy  = r_sy + w_xx2;
                    n_err = r_err + r_edy;
                    n_edy = r_edy + w_xx2;
                end else begin
                    n_ex  = r_ex + COORD_W'(1);
                    n_sx  = r_sx + w_yy2;
                    n_err = r_err + r_edx;
                    n_edx = r_edx + w_yy2;
                end
                n_state = S_EUB;
            end

            // Midpoint step, second half
            S_EUB: begin
                if (w_t > 0) begin
                    if (!r_ph) begin
                        n_ex  = r_ex - COORD_W'(1);
                        n_sx  = r_sx - w_yy2;
                        n_err = r_err + r_edx;
                        n_edx = r_edx + w_yy2;
                    end else begin
                        n_ey  = r_ey - COORD_W'(1);
                        n_sy  = r_sy - w_xx2;
                        n_err = r_err + r_edy;
                        n_edy = r_edy + w_xx2;
                    end
                end
                n_n = r_n + 11'd1;
                n_state = S_ETST;
            end

            // Span fill, row by row
            S_RRD: begin
                row_addr = r_r[7:0];
                n_state = S_RW;
            end
            S_RW: begin
                n_w    = w_wsel;
                n_i    = -w_wsel;
                n_half = 1'b0;
                n_state = S_SPAN;
            end
            S_SPAN: begin
                if (r_i > r_w) begin
                    n_state = S_SPR;
                end else begin
                    n_pv = 1'b1;
                    n_px = w_cx + r_i;
                    n_py = r_half ? w_cy - w_rr : w_cy + w_rr;
                    n_half = !r_half;
                    if (r_half) begin
                        n_i = r_i + COORD_W'(1);
                    end
                end
            end
            S_SPR: begin
                if (r_r >= 9'(r_ent.cmd.rad_y)) begin
                    n_state = S_DONE;
                end else begin
                    n_r = r_r + 9'd1;
                    n_state = S_RRD;
                end
            end

            // Pixel read waits for the plot stage to drain
            S_RD0: begin
                if (!r_pv) begin
                    n_state = w_rinb ? S_RD1 : S_DONE;
                end
            end
            S_RD1: begin
                n_rd = w_rdx[3:0];
                n_state = S_DONE;
            end

            S_DONE: begin
                n_ov = 1'b1;
                n_ores.read_shade   = r_rd;
                n_ores.command_done = 1'b1;
                n_state = S_IDLE;
            end

            default: n_state = S_CLR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ent  <= n_ent;
        r_px   <= n_px;
        r_py   <= n_py;
        r_lx   <= n_lx;
        r_ly   <= n_ly;
        r_ldx  <= n_ldx;
        r_ldy  <= n_ldy;
        r_lsx  <= n_lsx;
        r_lsy  <= n_lsy;
        r_lerr <= n_lerr;
        r_ex   <= n_ex;
        r_ey   <= n_ey;
        r_xx   <= n_xx;
        r_yy   <= n_yy;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_edx  <= n_edx;
        r_edy  <= n_edy;
        r_err  <= n_err;
        r_n    <= n_n;
        r_ph   <= n_ph;
        r_q    <= n_q;
        r_seen <= n_seen;
        r_r    <= n_r;
        r_w    <= n_w;
        r_i    <= n_i;
        r_half <= n_half;
        r_rd   <= n_rd;
        r_ores <= n_ores;
    end

    // Frame store
    fler_ram #(.W(SB), .D(DEPTH)) u_frame (
        .i_clk   (i_clk),
        .i_we    (fb_we),
        .i_waddr (fb_waddr),
        .i_wdata (fb_wdata),
        .i_raddr (fb_raddr),
        .o_rdata (fb_rdata)
    );

    // Per-row fill widths
    fler_ram #(.W(COORD_W), .D(ROW_SLOTS)) u_rows (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_addr),
        .i_wdata (row_wdata),
        .i_raddr (row_addr),
        .o_rdata (row_rdata)
    );

`ifndef SYNTH
    a_no_res_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_res_valid) else $error("result during clear");
    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid) else $error("result held two cycles");
    a_read_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD1) |-> $past(!r_pv)) else $error("read overtook a write");
`endif
endmodule

FILE: rtl/core/framebuffer_line_ellipse_raster.sv
// Ellipse outline: 4 store writes per traced point; filled ellipse: the widest
// column per row is recorded per traced point, then spans are drawn row by row.
// One command runs at a time; store writes peak at one pixel per cycle.
// Reset: synchronous; busy stays high while the frame store is zeroed.
// Results are a one-cycle strobe, never stalled.
module framebuffer_line_ellipse_raster #(
    parameter int SCREEN_COLUMNS = fler_pkg::SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = fler_pkg::SCREEN_ROWS,
    parameter int SHADE_BITS     = fler_pkg::SHADE_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  fler_pkg::t_cmd i_cmd,
    output logic           busy,
    output logic           o_res_valid,
    output fler_pkg::t_res o_res
);
    import fler_pkg::*;

    logic   q_valid;
    t_qent  q_ent;
    logic   q_pop;
    t_bstat bstat;

    // Command intake and queue
    fler_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_cmd     (i_cmd),
        .busy      (busy),
        .i_bstat   (bstat),
        .o_q_valid (q_valid),
        .o_q_ent   (q_ent),
        .i_q_pop   (q_pop)
    );

    // Drawing engine
    fler_back #(
        .COLS (SCREEN_COLUMNS),
        .ROWS (SCREEN_ROWS),
        .SB   (SHADE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_ent     (q_ent),
        .o_q_pop     (q_pop),
        .o_bstat     (bstat),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );
endmodule
